FILE: rtl/core/fir_filter_circular_macros.svh
// Assertion macros shared by the RTL of the circular FIR filter.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef FIR_FILTER_CIRCULAR_MACROS_SVH
`define FIR_FILTER_CIRCULAR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever cond holds, prop must hold in the same cycle.
`define FIRC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("implication check failed");

// Whenever cond holds, prop must hold in the following cycle.
`define FIRC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`else

`define FIRC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define FIRC_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/core/firc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package firc_pkg;

	localparam int SAMP_W   = 16;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = SAMP_W + COEF_W;
	localparam int FRAC_W   = 15;
	localparam int NT_W     = 6;
	localparam int CI_W     = 5;
	localparam int TAPS_DEF = 32;

	localparam logic [NT_W-1:0] NT_RESET = NT_W'(32);

	// Control that the sequencer broadcasts to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic active;
		logic last;
	} cell_ctrl_t;

	// Marks that travel with one tap pair through the multiply-accumulate.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} tap_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/firc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One tap position: holds a coefficient and a history sample.
// The coefficient ring turns toward higher indexes, the history ring toward lower ones.
module firc_cell import firc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic                     coef_ld,
	input  logic signed [COEF_W-1:0] coef_ld_val,
	input  logic                     hist_wr,
	input  logic signed [SAMP_W-1:0] hist_wr_val,
	input  logic signed [COEF_W-1:0] coef_prev,
	input  logic signed [SAMP_W-1:0] hist_next,
	input  logic signed [SAMP_W-1:0] hist_head,
	output logic signed [COEF_W-1:0] coef,
	output logic signed [SAMP_W-1:0] hist
);

	logic signed [COEF_W-1:0] coef_q;
	logic signed [SAMP_W-1:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			hist_q <= '0;
		end else begin
			if (coef_ld) begin
				coef_q <= coef_ld_val;
			end else if (ctrl.shift && ctrl.active) begin
				coef_q <= coef_prev;
			end
			if (hist_wr) begin
				hist_q <= hist_wr_val;
			end else if (ctrl.shift && ctrl.active) begin
				// The last active cell closes the ring from position zero.
				hist_q <= ctrl.last ? hist_head : hist_next;
			end
		end
	end

	assign coef = coef_q;
	assign hist = hist_q;

endmodule

`default_nettype wire

FILE: rtl/core/firc_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply-accumulate with floor scaling and saturation of the final sum.
module firc_mac import firc_pkg::*; #(
	parameter int ACC_W = PROD_W + 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  tap_ctrl_t                tap_s1,
	input  logic signed [COEF_W-1:0] coef_s1,
	input  logic signed [SAMP_W-1:0] hist_s1,
	output logic                     done,
	output logic signed [SAMP_W-1:0] result
);

	localparam int Q_W = ACC_W - FRAC_W;
	localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((1 << (SAMP_W - 1)) - 1);
	localparam logic signed [Q_W-1:0] SAT_MIN = Q_W'(-(1 << (SAMP_W - 1)));
	localparam logic signed [SAMP_W-1:0] RES_MAX = SAMP_W'((1 << (SAMP_W - 1)) - 1);
	localparam logic signed [SAMP_W-1:0] RES_MIN = SAMP_W'(-(1 << (SAMP_W - 1)));

	tap_ctrl_t                ctrl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [Q_W-1:0]    scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= tap_s1;
			if (start) begin
				done_q <= 1'b0;
			end else if (ctrl_s2.vld && ctrl_s2.last) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * hist_s1;
		if (ctrl_s2.vld) begin
			acc_q <= ctrl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// An arithmetic shift rounds toward minus infinity.
	assign scaled = Q_W'(acc_q >>> FRAC_W);

	always_comb begin
		if (scaled > SAT_MAX) begin
			result = RES_MAX;
		end else if (scaled < SAT_MIN) begin
			result = RES_MIN;
		end else begin
			result = SAMP_W'(scaled);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/fir_filter_circular.sv
`timescale 1ns / 1ps
`default_nettype none

// Direct-form FIR filter over a circular sample history, Q1.15 samples and coefficients.
// An input transfer with kind 0 loads coef_value into tap coef_index and gives
// no result; an index at or above TAPS is ignored. A transfer with kind 1 writes sample at
// the write pointer, forms the sum of coefficient j times the sample j steps back over the
// active taps, and gives one filtered value: the exact sum shifted right by 15 (rounding
// toward minus infinity) and saturated to 16 bits. The number of active taps is num_taps,
// written through cfg_we/cfg_wdata while the block is idle; zero acts as one and values
// above TAPS act as TAPS. For a sample item the coefficient and history rings turn once,
// one tap position a cycle, past a single shared multiplier, followed by the multiply,
// the accumulate and the output load. Coefficients and history reset to zero at once,
// so no clearing pass is needed.
// A finished value waits in the output register while the next item is taken.

`include "fir_filter_circular_macros.svh"

module fir_filter_circular import firc_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [NT_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic [CI_W-1:0]          coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic signed [SAMP_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SAMP_W-1:0] filtered
);

	localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int NT_MAX = (1 << NT_W) - 1;
	localparam int N_MAX  = (TAPS < NT_MAX) ? TAPS : NT_MAX;
	localparam int CMP_W  = (IDX_W > NT_W) ? IDX_W : NT_W;
	localparam int ACC_W  = PROD_W + $clog2(N_MAX + 1);
	localparam logic [NT_W-1:0] N_CAP = NT_W'(N_MAX);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                   state_q;
	logic [NT_W-1:0]          num_taps_q;
	logic [NT_W-1:0]          n_eff;
	logic [IDX_W-1:0]         wp_q;
	logic [IDX_W-1:0]         wp_eff;
	logic [CMP_W-1:0]         wp_plus;
	logic [IDX_W-1:0]         wp_next;
	logic [IDX_W-1:0]         last_idx;
	logic [NT_W-1:0]          cnt_q;
	logic                     cnt_last;
	logic                     in_xfer;
	logic                     start;
	logic                     out_load;
	logic                     out_valid_q;
	logic signed [SAMP_W-1:0] filtered_q;
	logic                     acc_done;
	logic signed [SAMP_W-1:0] mac_result;
	tap_ctrl_t                tap_s1;
	logic signed [COEF_W-1:0] coef_s1;
	logic signed [SAMP_W-1:0] hist_s1;

	logic signed [COEF_W-1:0] coef_w [TAPS];
	logic signed [SAMP_W-1:0] hist_w [TAPS];

	// The tap count register. The user must write it only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NT_RESET;
		end else if (cfg_we) begin
			num_taps_q <= cfg_wdata;
		end
	end

	// Effective tap count: zero behaves as one, anything above the store depth as the depth.
	always_comb begin
		if (num_taps_q == '0) begin
			n_eff = NT_W'(1);
		end else if (num_taps_q > N_CAP) begin
			n_eff = N_CAP;
		end else begin
			n_eff = num_taps_q;
		end
	end

	// If the tap count was lowered below the pointer, the pointer restarts at zero before
	// the new sample is written.
	assign wp_eff   = (CMP_W'(wp_q) >= CMP_W'(n_eff)) ? '0 : wp_q;
	assign wp_plus  = CMP_W'(wp_q) + CMP_W'(1);
	assign wp_next  = (wp_plus >= CMP_W'(n_eff)) ? '0 : IDX_W'(wp_plus);
	assign last_idx = IDX_W'(n_eff - NT_W'(1));
	assign cnt_last = (cnt_q == n_eff - NT_W'(1));

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign start    = in_xfer && kind;

	// The rings. Each turn moves every active coefficient one cell up (the last active one
	// wraps to cell zero) and every active history sample one cell down (cell zero wraps to
	// the last active cell). After s turns cell zero holds coefficient (-s mod n) and the
	// cell at the write pointer holds the sample written (s mod n) positions later in the
	// ring, so each pair read there is one term of the convolution. After n turns both
	// rings are back where they started.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		cell_ctrl_t               ctrl;
		logic signed [COEF_W-1:0] coef_prev;
		logic signed [SAMP_W-1:0] hist_next;

		assign ctrl.shift  = (state_q == ST_RUN);
		assign ctrl.active = (CMP_W'(k) < CMP_W'(n_eff));
		assign ctrl.last   = (CMP_W'(k) == CMP_W'(n_eff) - CMP_W'(1));

		if (k == 0) begin : g_head
			assign coef_prev = coef_w[last_idx];
		end else begin : g_body
			assign coef_prev = coef_w[k-1];
		end

		if (k == TAPS - 1) begin : g_tail
			assign hist_next = hist_w[0];
		end else begin : g_inner
			assign hist_next = hist_w[k+1];
		end

		firc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.coef_ld     (in_xfer && !kind && (int'(coef_index) == k)),
			.coef_ld_val (coef_value),
			.hist_wr     (start && (wp_eff == IDX_W'(k))),
			.hist_wr_val (sample),
			.coef_prev   (coef_prev),
			.hist_next   (hist_next),
			.hist_head   (hist_w[0]),
			.coef        (coef_w[k]),
			.hist        (hist_w[k])
		);
	end

	// Sequencer: a sample transfer starts n turns of the rings, then the block waits for
	// the accumulator and a free output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			cnt_q   <= '0;
			tap_s1  <= '0;
		end else begin
			tap_s1.vld   <= (state_q == ST_RUN);
			tap_s1.first <= (cnt_q == '0);
			tap_s1.last  <= cnt_last;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						wp_q    <= wp_eff;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + NT_W'(1);
					if (cnt_last) begin
						wp_q    <= wp_next;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tap pair feeding the multiplier, taken from the two fixed read points of the rings.
	always_ff @(posedge clk) begin
		coef_s1 <= coef_w[0];
		hist_s1 <= hist_w[wp_q];
	end

	firc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.tap_s1  (tap_s1),
		.coef_s1 (coef_s1),
		.hist_s1 (hist_s1),
		.done    (acc_done),
		.result  (mac_result)
	);

	// Output register. It decouples the result from the next item, which may already be
	// accepted while this value waits for its transfer.
	assign out_load = (state_q == ST_DRAIN) && acc_done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= mac_result;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	`FIRC_ASSERT_NEXT(a_sample_starts_run, clk, arst_n, start, state_q == ST_RUN)
	`FIRC_ASSERT_NEXT(a_coef_load_stays_idle, clk, arst_n, in_xfer && !kind, state_q == ST_IDLE)
	`FIRC_ASSERT_IMPLIES(a_run_count_in_range, clk, arst_n, state_q == ST_RUN, cnt_q < n_eff)
	`FIRC_ASSERT_IMPLIES(a_result_from_drain, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_DRAIN)

endmodule

`default_nettype wire

FILE: tb/fir_filter_circular_tb.sv
`timescale 1ns / 1ps

module fir_filter_circular_tb;
	import firc_pkg::*;

	// One input transfer as the driver presents it.
	typedef struct {
		logic                     kind;
		logic [CI_W-1:0]          coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [SAMP_W-1:0] sample;
	} fir_item_t;

	// The kinds of input transfer.
	localparam logic KIND_LOAD_COEF = 1'b0;
	localparam logic KIND_FILTER    = 1'b1;

	// The run never needs more than a fraction of this; it only catches a hung block.
	localparam int CYCLE_LIMIT = 600000;
	// This tail is ample for the block to finish a sample at the full tap count.
	localparam int SETTLE_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 105;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [NT_W-1:0]          cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = 1'b0;
	logic [CI_W-1:0]          coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic signed [SAMP_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [SAMP_W-1:0] filtered;

	// Our own copy of the filter state, advanced once per accepted input transfer.
	logic signed [COEF_W-1:0] coef_store [TAPS_DEF];
	logic signed [SAMP_W-1:0] history [TAPS_DEF];
	int unsigned              hist_ptr;
	logic [NT_W-1:0]          taps_reg;

	fir_item_t                pending_items [$];
	logic signed [SAMP_W-1:0] expected_filtered [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;

	fir_filter_circular DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filtered   (filtered)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reports one failure; only the first ten are printed in full.
	task automatic flag_error(string what);
		err_count++;
		if (err_count <= 10) begin
			$display("ERROR @%0t: %s", $realtime, what);
		end
	endtask

	// Applies one accepted transfer to the filter state. A coefficient load just writes
	// the store (every 5-bit index lands inside the 32-entry store). A sample is written at
	// the write pointer, and the dot product of the coefficients with the history, newest
	// sample first, is formed exactly in 64 bits before it is scaled back to Q1.15.
	task automatic apply_transfer(fir_item_t it);
		int unsigned n;
		int unsigned idx;
		longint      acc;
		longint      q;
		if (it.kind == KIND_LOAD_COEF) begin
			coef_store[it.coef_index] = it.coef_value;
		end else begin
			// A tap count of zero behaves as one, anything past the store as the full store.
			n = (taps_reg == 0) ? 1 : ((taps_reg > TAPS_DEF) ? TAPS_DEF : taps_reg);
			// After the tap count has been lowered the pointer may lie past the ring.
			if (hist_ptr >= n) begin
				hist_ptr = 0;
			end
			history[hist_ptr] = it.sample;
			acc = 0;
			for (int unsigned j = 0; j < n; j++) begin
				idx = hist_ptr + n - j;
				if (idx >= n) begin
					idx -= n;
				end
				acc += longint'(coef_store[j]) * longint'(history[idx]);
			end
			// An arithmetic shift of a signed value rounds toward minus infinity.
			q = acc >>> FRAC_W;
			if (q > 32767) begin
				q = 32767;
			end else if (q < -32768) begin
				q = -32768;
			end
			expected_filtered.push_back(SAMP_W'(q));
			hist_ptr++;
			if (hist_ptr >= n) begin
				hist_ptr = 0;
			end
		end
	endtask

	// Random content. Coefficients are often kept small so that the output does not sit at
	// the rails all the time, but full-range values and the extremes show up as well.
	function automatic fir_item_t random_item();
		fir_item_t it;
		it.kind = ($urandom_range(99) < 25) ? KIND_LOAD_COEF : KIND_FILTER;
		it.coef_index = CI_W'($urandom_range(31));
		case ($urandom_range(3))
			0: it.coef_value = COEF_W'($urandom);
			1: it.coef_value = COEF_W'(int'($urandom_range(4095)) - 2048);
			2: it.coef_value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: it.coef_value = COEF_W'(int'($urandom_range(511)) - 256);
		endcase
		case ($urandom_range(9))
			0: it.sample = 16'sh7fff;
			1: it.sample = 16'sh8000;
			default: it.sample = SAMP_W'($urandom);
		endcase
		return it;
	endfunction

	function automatic fir_item_t make_item(logic k, int ci, int cv, int s);
		fir_item_t it;
		it.kind = k;
		it.coef_index = CI_W'(ci);
		it.coef_value = COEF_W'(cv);
		it.sample = SAMP_W'(s);
		return it;
	endfunction

	// Blocks until every queued transfer has gone in and every result has come out, then
	// lets the block finish anything it might still be doing.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_filtered.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The tap count register is only written while the block is idle.
	task automatic write_taps(logic [NT_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		taps_reg = value;
	endtask

	// Input side. A transfer happens at an edge where in_valid is high and in_stall low;
	// only then (or while nothing is offered) may the next item be put on the port. The
	// choice to idle is made without looking at in_stall.
	always @(posedge clk) begin : drive_inputs
		fir_item_t nxt;
		fir_item_t cur;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				cur.kind = kind;
				cur.coef_index = coef_index;
				cur.coef_value = coef_value;
				cur.sample = sample;
				apply_transfer(cur);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					in_valid <= 1'b1;
					kind <= nxt.kind;
					coef_index <= nxt.coef_index;
					coef_value <= nxt.coef_value;
					sample <= nxt.sample;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: every transfer is checked against the oldest expected value, and the
	// stall is redrawn every cycle.
	always @(posedge clk) begin : watch_outputs
		logic signed [SAMP_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_filtered.size() == 0) begin
					flag_error($sformatf("unexpected result filtered=%0d", filtered));
				end else begin
					want = expected_filtered.pop_front();
					if (filtered !== want) begin
						flag_error($sformatf("filtered: expected %0d, got %0d", want, filtered));
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog against a block that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : run_test
		logic [NT_W-1:0] taps_plan [8];
		for (int i = 0; i < TAPS_DEF; i++) begin
			coef_store[i] = '0;
			history[i] = '0;
		end
		hist_ptr = 0;
		taps_reg = NT_RESET;
		// The single tap, zero and the largest register value cover the edge cases of the
		// tap count; 5 after 63 lowers it below a pointer that has run ahead.
		taps_plan = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd32, 6'd33, 6'd2, 6'd17};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset tap count of 32. Ignored fields carry noise on purpose.
		pending_items.push_back(make_item(KIND_LOAD_COEF, 0, 32767, -32768));
		pending_items.push_back(make_item(KIND_FILTER, 31, -1, 32767));
		pending_items.push_back(make_item(KIND_FILTER, 0, 32767, -32768));
		// Most negative times most negative overflows Q1.15 and has to clip high.
		pending_items.push_back(make_item(KIND_LOAD_COEF, 0, -32768, 32767));
		pending_items.push_back(make_item(KIND_FILTER, 17, 12345, -32768));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, 32767));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 1, -32768, 0));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, -32768));
		// A lone product of minus one must round down to minus one, not to zero.
		pending_items.push_back(make_item(KIND_LOAD_COEF, 0, 1, 0));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 1, 0, 0));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, -1));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, 1));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 31, -32768, -1));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 30, 32767, 0));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, 0));
		// Several large negative taps against full-scale samples clip low.
		pending_items.push_back(make_item(KIND_LOAD_COEF, 0, -32768, 0));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 1, -32768, 0));
		pending_items.push_back(make_item(KIND_LOAD_COEF, 2, -32768, 0));
		pending_items.push_back(make_item(KIND_FILTER, 31, 32767, 32767));
		pending_items.push_back(make_item(KIND_FILTER, 0, -32768, 32767));
		pending_items.push_back(make_item(KIND_FILTER, 0, 0, 32767));
		pending_items.push_back(make_item(KIND_FILTER, 21, 21, -32768));
		wait_drained();

		// Random part: each phase has its own tap count and its own idling pattern, cycling
		// through no idling, a slow sender, a slow receiver and both at once.
		for (int p = 0; p < 8; p++) begin
			write_taps(taps_plan[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			repeat (ITEMS_PER_PHASE) pending_items.push_back(random_item());
			wait_drained();
		end

		if (err_count == 0 && expected_filtered.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
